@@ design/world_point_to_radar_screen_core_defines.svh @@
// Assertion macros for the radar screen mapper.
// Needs i_clk and i_rst_n in the scope where the macros are used.
`ifndef WORLD_POINT_TO_RADAR_SCREEN_CORE_DEFINES_SVH
`define WORLD_POINT_TO_RADAR_SCREEN_CORE_DEFINES_SVH

// same-cycle implication
`define WPRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wprs check failed");

// next-cycle implication
`define WPRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wprs check failed");

`endif

@@ design/wprs_pkg.sv @@
// Shared constants and types for the radar screen mapper.
// No dependencies; used by the channel interfaces and the core.
package wprs_pkg;
    localparam int COORD_BITS_DEF  = 17;
    localparam int ANGLE_BITS_DEF  = 16;
    localparam int SCREEN_BITS_DEF = 12;

    localparam int RANGE_BITS    = 16;
    localparam int ORIGIN_BITS   = 11;
    localparam int SIZE_BITS     = 12;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;

    localparam int TRIG_BITS   = 17;
    localparam int PHASE_BITS  = 32;
    localparam int FRAC_BITS   = 30;
    localparam int Q_BITS      = 12;
    localparam int EDGE_MARGIN = 5;

    localparam logic [RANGE_BITS-1:0]  VIEW_RANGE_RST = 16'd2048;
    localparam logic [SIZE_BITS-1:0]   PANEL_SIZE_RST = 12'd200;

    localparam logic [31:0] K9 = 32'd172271;
    localparam logic [31:0] HORNER_K [4] = '{
        32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VIEW_RANGE   = 3'd0,
        REG_PANEL_LEFT   = 3'd1,
        REG_PANEL_TOP    = 3'd2,
        REG_PANEL_WIDTH  = 3'd3,
        REG_PANEL_HEIGHT = 3'd4
    } t_cfg_reg;
endpackage

@@ design/wprs_in_if.sv @@
// Input channel: target and viewer points plus viewer yaw.
// Widths default from wprs_pkg.
interface wprs_in_if #(
    parameter int COORD_BITS = wprs_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = wprs_pkg::ANGLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] target_x;
    logic signed [COORD_BITS-1:0] target_y;
    logic signed [COORD_BITS-1:0] viewer_x;
    logic signed [COORD_BITS-1:0] viewer_y;
    logic        [ANGLE_BITS-1:0] view_yaw;

    modport source (output valid, target_x, target_y, viewer_x, viewer_y, view_yaw,
                    input ready);
    modport sink   (input valid, target_x, target_y, viewer_x, viewer_y, view_yaw,
                    output ready);
endinterface

@@ design/wprs_out_if.sv @@
// Output channel: clamped screen pixel position.
// Width defaults from wprs_pkg.
interface wprs_out_if #(
    parameter int SCREEN_BITS = wprs_pkg::SCREEN_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SCREEN_BITS-1:0] screen_x;
    logic [SCREEN_BITS-1:0] screen_y;

    modport source (output valid, screen_x, screen_y, input ready);
    modport sink   (input valid, screen_x, screen_y, output ready);
endinterface

@@ design/world_point_to_radar_screen_core.sv @@
// Radar screen mapper core: a registered pipeline from input beat to output beat.
// Throughput one beat per cycle unless the output stalls; the multiplier chain of the
// quarter-sine and the twelve restoring divide steps each hold one register stage.
// An output stall freezes every stage; nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and loads register defaults.
// Depends on wprs_pkg, wprs_in_if, wprs_out_if and the defines header.
`include "world_point_to_radar_screen_core_defines.svh"

module world_point_to_radar_screen_core #(
    parameter int COORD_BITS  = wprs_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS  = wprs_pkg::ANGLE_BITS_DEF,
    parameter int SCREEN_BITS = wprs_pkg::SCREEN_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wprs_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [wprs_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    wprs_in_if.sink                            i_in,
    wprs_out_if.source                         o_out
);
    import wprs_pkg::*;

    localparam int CW   = COORD_BITS;
    localparam int DW   = CW + 1;
    localparam int PRW  = DW + TRIG_BITS;
    localparam int RW   = CW + 19;
    localparam int NW   = RW + Q_BITS;
    localparam int PW   = (SCREEN_BITS > 14) ? SCREEN_BITS + 2 : 16;
    localparam int DIV0 = 12;
    localparam int NSTG = DIV0 + Q_BITS + 1;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic signed [PW-1:0] MARGIN = PW'(EDGE_MARGIN);
    localparam logic signed [PW-1:0] LIM    = PW'((1 << SCREEN_BITS) - 1);

    logic [RANGE_BITS-1:0]  r_view_range;
    logic [ORIGIN_BITS-1:0] r_panel_left;
    logic [ORIGIN_BITS-1:0] r_panel_top;
    logic [SIZE_BITS-1:0]   r_panel_width;
    logic [SIZE_BITS-1:0]   r_panel_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_range   <= VIEW_RANGE_RST;
            r_panel_left   <= '0;
            r_panel_top    <= '0;
            r_panel_width  <= PANEL_SIZE_RST;
            r_panel_height <= PANEL_SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_VIEW_RANGE:   r_view_range   <= i_cfg_data;
                REG_PANEL_LEFT:   r_panel_left   <= i_cfg_data[ORIGIN_BITS-1:0];
                REG_PANEL_TOP:    r_panel_top    <= i_cfg_data[ORIGIN_BITS-1:0];
                REG_PANEL_WIDTH:  r_panel_width  <= i_cfg_data[SIZE_BITS-1:0];
                REG_PANEL_HEIGHT: r_panel_height <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic            en;
    logic [NSTG-1:0] r_v;

    assign en          = !o_out.valid || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], i_in.valid};
        end
    end

    // offsets, quadrant and trig lanes (lane 0 sine of f, lane 1 sine of 1-f)
    logic signed [DW-1:0] r_dx [0:7];
    logic signed [DW-1:0] r_dy [0:7];
    logic [1:0]           r_quad [0:6];
    logic [30:0]          r_f [2][0:5];
    logic [30:0]          r_z [2][1:4];
    logic [31:0]          r_r [2][2:5];
    logic [31:0]          r_sn [2];
    logic signed [TRIG_BITS-1:0] r_s;
    logic signed [TRIG_BITS-1:0] r_c;
    logic signed [PRW-1:0] r_xs, r_yc, r_xc, r_ys;
    logic signed [RW-1:0]  r_rx, r_ry;
    logic [RW-1:0]         r_a [2];
    logic [SIZE_BITS-1:0]  r_m [2];
    logic [RW-1:0]         r_den [2];
    logic                  r_neg [2];
    logic [NW-1:0]         r_num [2];
    logic [RW-1:0]         r_nden [2];
    logic                  r_nneg [2];
    logic [NW-1:0]         r_rem [2][Q_BITS];
    logic [RW-1:0]         r_dden [2][Q_BITS];
    logic [Q_BITS-1:0]     r_q [2][Q_BITS];
    logic                  r_dneg [2][Q_BITS];
    logic [SCREEN_BITS-1:0] r_pix [2];

    logic [31:0]          d_phase;
    logic [30:0]          d_f;
    logic signed [DW-1:0] d_dx, d_dy;

    always_comb begin
        d_phase = 32'(i_in.view_yaw) << (PHASE_BITS - ANGLE_BITS);
        d_f     = {1'b0, d_phase[FRAC_BITS-1:0]};
        d_dx    = $signed({i_in.target_x[CW-1], i_in.target_x})
                - $signed({i_in.viewer_x[CW-1], i_in.viewer_x});
        d_dy    = $signed({i_in.target_y[CW-1], i_in.target_y})
                - $signed({i_in.viewer_y[CW-1], i_in.viewer_y});
    end

    // round, saturate and pick sine and cosine by quadrant
    logic [31:0]                 d_tr [2];
    logic signed [TRIG_BITS-1:0] d_sq [2];
    logic signed [TRIG_BITS-1:0] d_s, d_c;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            d_tr[l] = (r_sn[l] + 32'd16384) >> 15;
            if (d_tr[l] > 32'd32767) begin
                d_sq[l] = TRIG_BITS'(32767);
            end else begin
                d_sq[l] = $signed(d_tr[l][TRIG_BITS-1:0]);
            end
        end
        case (r_quad[6])
            2'd0:    begin d_s = d_sq[0];  d_c = d_sq[1];  end
            2'd1:    begin d_s = d_sq[1];  d_c = -d_sq[0]; end
            2'd2:    begin d_s = -d_sq[0]; d_c = -d_sq[1]; end
            default: begin d_s = -d_sq[1]; d_c = d_sq[0];  end
        endcase
    end

    // range test, edge branch and divide operands per axis
    logic [RW-1:0]        d_ax, d_ay, d_rng;
    logic                 d_oor, d_g1, d_g2;
    logic [RW-1:0]        d_a [2];
    logic [SIZE_BITS-1:0] d_m [2];
    logic [RW-1:0]        d_den [2];
    logic                 d_neg [2];

    always_comb begin
        d_ax  = r_rx[RW-1] ? RW'(-r_rx) : RW'(r_rx);
        d_ay  = r_ry[RW-1] ? RW'(-r_ry) : RW'(r_ry);
        d_rng = RW'({r_view_range, 15'b0});
        d_oor = (d_ax > d_rng) || (d_ay > d_rng);
        d_g1  = r_ry > r_rx;
        d_g2  = r_ry > -r_rx;
        d_a[0]   = d_ax;      d_m[0] = r_panel_width;
        d_den[0] = d_rng;     d_neg[0] = r_rx[RW-1];
        d_a[1]   = d_ay;      d_m[1] = r_panel_height;
        d_den[1] = d_rng;     d_neg[1] = r_ry[RW-1];
        if (d_oor) begin
            if (d_g1 == d_g2) begin
                d_den[0] = d_ay;
                d_a[1]   = RW'(1);
                d_den[1] = RW'(1);
                d_neg[1] = !d_g1;
            end else begin
                d_den[1] = d_ax;
                d_a[0]   = RW'(1);
                d_den[0] = RW'(1);
                d_neg[0] = d_g1;
            end
        end else if (r_view_range == '0) begin
            d_a[0]   = '0;
            d_a[1]   = '0;
            d_den[0] = RW'(1);
            d_den[1] = RW'(1);
        end
    end

    // restoring divide steps
    logic [NW-1:0]     d_rin [2][Q_BITS];
    logic [RW-1:0]     d_din [2][Q_BITS];
    logic [Q_BITS-1:0] d_qin [2][Q_BITS];
    logic              d_nin [2][Q_BITS];
    logic [NW-1:0]     d_sh  [2][Q_BITS];
    logic              d_ge  [2][Q_BITS];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            for (int j = 0; j < Q_BITS; j++) begin
                if (j == 0) begin
                    d_rin[l][j] = r_num[l];
                    d_din[l][j] = r_nden[l];
                    d_qin[l][j] = '0;
                    d_nin[l][j] = r_nneg[l];
                end else begin
                    d_rin[l][j] = r_rem[l][j-1];
                    d_din[l][j] = r_dden[l][j-1];
                    d_qin[l][j] = r_q[l][j-1];
                    d_nin[l][j] = r_dneg[l][j-1];
                end
                d_sh[l][j] = NW'(d_din[l][j]) << (Q_BITS - 1 - j);
                d_ge[l][j] = d_rin[l][j] >= d_sh[l][j];
            end
        end
    end

    // offset into the panel and clamp
    logic [ORIGIN_BITS-1:0] d_org_u [2];
    logic [SIZE_BITS-1:0]   d_sz_u  [2];
    logic signed [PW-1:0]   d_org, d_sz, d_off, d_top, d_p;
    logic [SCREEN_BITS-1:0] n_pix [2];

    always_comb begin
        d_org_u[0] = r_panel_left;
        d_org_u[1] = r_panel_top;
        d_sz_u[0]  = r_panel_width;
        d_sz_u[1]  = r_panel_height;
        d_org = '0;
        d_sz  = '0;
        d_off = '0;
        d_top = '0;
        d_p   = '0;
        for (int l = 0; l < 2; l++) begin
            d_org = $signed(PW'(d_org_u[l]));
            d_sz  = $signed(PW'(d_sz_u[l]));
            d_off = $signed(PW'(r_q[l][Q_BITS-1]));
            if (r_dneg[l][Q_BITS-1]) begin
                d_off = -d_off;
            end
            d_top = d_org + d_sz - MARGIN;
            d_p   = d_org + (d_sz >>> 1) + d_off;
            if (d_p > d_top) begin
                d_p = d_top;
            end
            if (d_p < d_org) begin
                d_p = d_org;
            end
            if (d_p > LIM) begin
                d_p = LIM;
            end
            if (d_p < 0) begin
                d_p = '0;
            end
            n_pix[l] = d_p[SCREEN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx[0]   <= d_dx;
            r_dy[0]   <= d_dy;
            r_quad[0] <= d_phase[PHASE_BITS-1:FRAC_BITS];
            r_f[0][0] <= d_f;
            r_f[1][0] <= ONE_Q30 - d_f;
            for (int i = 1; i <= 7; i++) begin
                r_dx[i] <= r_dx[i-1];
                r_dy[i] <= r_dy[i-1];
            end
            for (int i = 1; i <= 6; i++) begin
                r_quad[i] <= r_quad[i-1];
            end
            for (int l = 0; l < 2; l++) begin
                for (int i = 1; i <= 5; i++) begin
                    r_f[l][i] <= r_f[l][i-1];
                end
                r_z[l][1] <= 31'((64'(r_f[l][0]) * 64'(r_f[l][0])) >> FRAC_BITS);
                for (int i = 2; i <= 4; i++) begin
                    r_z[l][i] <= r_z[l][i-1];
                end
                r_r[l][2] <= HORNER_K[0] - 32'((64'(K9) * 64'(r_z[l][1])) >> FRAC_BITS);
                for (int i = 3; i <= 5; i++) begin
                    r_r[l][i] <= HORNER_K[i-2]
                               - 32'((64'(r_r[l][i-1]) * 64'(r_z[l][i-1])) >> FRAC_BITS);
                end
                r_sn[l] <= 32'((64'(r_r[l][5]) * 64'(r_f[l][5])) >> FRAC_BITS);
            end
            r_s  <= d_s;
            r_c  <= d_c;
            r_xs <= r_dx[7] * r_s;
            r_yc <= r_dy[7] * r_c;
            r_xc <= r_dx[7] * r_c;
            r_ys <= r_dy[7] * r_s;
            r_rx <= RW'(r_xs) - RW'(r_yc);
            r_ry <= -RW'(r_xc) - RW'(r_ys);
            for (int l = 0; l < 2; l++) begin
                r_a[l]    <= d_a[l];
                r_m[l]    <= d_m[l];
                r_den[l]  <= d_den[l];
                r_neg[l]  <= d_neg[l];
                r_num[l]  <= NW'(r_a[l]) * NW'(r_m[l]);
                r_nden[l] <= r_den[l];
                r_nneg[l] <= r_neg[l];
                for (int j = 0; j < Q_BITS; j++) begin
                    r_rem[l][j]  <= d_ge[l][j] ? d_rin[l][j] - d_sh[l][j] : d_rin[l][j];
                    r_q[l][j]    <= d_qin[l][j]
                                  | (d_ge[l][j] ? Q_BITS'(1) << (Q_BITS - 1 - j) : '0);
                    r_dden[l][j] <= d_din[l][j];
                    r_dneg[l][j] <= d_nin[l][j];
                end
                r_pix[l] <= n_pix[l];
            end
        end
    end

    assign o_out.screen_x = r_pix[0];
    assign o_out.screen_y = r_pix[1];

    `WPRS_ASSERT_NEXT(a_stall_freeze, !en, $stable(r_v))
    `WPRS_ASSERT_NOW(a_den_nonzero, r_v[10], (r_den[0] != '0) && (r_den[1] != '0))
    `WPRS_ASSERT_NOW(a_div_rem_x, r_v[DIV0+Q_BITS-1], r_rem[0][Q_BITS-1] < NW'(r_dden[0][Q_BITS-1]))
    `WPRS_ASSERT_NOW(a_div_rem_y, r_v[DIV0+Q_BITS-1], r_rem[1][Q_BITS-1] < NW'(r_dden[1][Q_BITS-1]))
endmodule

@@ tb/sv/world_point_to_radar_screen_core_test.sv @@
// Testbench for world_point_to_radar_screen_core: directed table, fixed panel cases,
// then random points; results checked against an in-bench predictor or table values.
// Depends on wprs_pkg, wprs_in_if, wprs_out_if and the core.
`timescale 1ns / 1ps

module world_point_to_radar_screen_core_test;
    import wprs_pkg::*;

    localparam int CB = COORD_BITS_DEF;
    localparam int AB = ANGLE_BITS_DEF;
    localparam int SB = SCREEN_BITS_DEF;
    localparam int LATENCY = 25;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 680;

    typedef struct packed {
        logic signed [CB-1:0] tx;
        logic signed [CB-1:0] ty;
        logic signed [CB-1:0] vx;
        logic signed [CB-1:0] vy;
        logic [AB-1:0]        yaw;
    } t_point;

    typedef struct packed {
        logic [SB-1:0] sx;
        logic [SB-1:0] sy;
    } t_pixel;

    typedef struct {
        t_point p;
        logic   known;
        t_pixel px;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    wprs_in_if  #(.COORD_BITS(CB), .ANGLE_BITS(AB)) in_ch ();
    wprs_out_if #(.SCREEN_BITS(SB)) out_ch ();

    world_point_to_radar_screen_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always #1 i_clk = ~i_clk;

    longint view_range, panel_left, panel_top, panel_width, panel_height;
    t_pixel pixels_due[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit sink_idle_ok = 1'b1;
    bit hold_off = 1'b0;
    bit src_idle_ok = 1'b1;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.target_x = '0;
        in_ch.target_y = '0;
        in_ch.viewer_x = '0;
        in_ch.viewer_y = '0;
        in_ch.view_yaw = '0;
        out_ch.ready = 1'b0;
    end

    function automatic longint quarter_sine(longint unsigned f);
        longint unsigned z, r;
        z = (f * f) >> 30;
        r = 64'd172271;
        r = 64'd5026995 - ((r * z) >> 30);
        r = 64'd85569306 - ((r * z) >> 30);
        r = 64'd693598668 - ((r * z) >> 30);
        r = 64'd1686629713 - ((r * z) >> 30);
        r = (r * f) >> 30;
        r = (r + 16384) >> 15;
        if (r > 32767) r = 32767;
        return longint'(r);
    endfunction

    function automatic longint clamp_pixel(longint origin, longint size, longint off);
        longint top, p;
        top = origin + size - EDGE_MARGIN;
        p = origin + (size / 2 + off);
        if (p > top) p = top;
        if (p < origin) p = origin;
        if (p > (1 << SB) - 1) p = (1 << SB) - 1;
        if (p < 0) p = 0;
        return p;
    endfunction

    function automatic t_pixel radar_pixel(t_point p);
        longint dx, dy, sf, sg, s, c, rx, ry, rng, w, h, ax, ay, ox, oy;
        longint unsigned phase, f;
        t_pixel px;
        dx = longint'(p.tx) - longint'(p.vx);
        dy = longint'(p.ty) - longint'(p.vy);
        phase = (longint'(p.yaw) << (32 - AB)) & 64'hFFFF_FFFF;
        f = phase & ((64'd1 << 30) - 1);
        sf = quarter_sine(f);
        sg = quarter_sine((64'd1 << 30) - f);
        case (phase >> 30)
            0: begin s = sf; c = sg; end
            1: begin s = sg; c = -sf; end
            2: begin s = -sf; c = -sg; end
            default: begin s = -sg; c = sf; end
        endcase
        rx = -dy * c + dx * s;
        ry = -dx * c - dy * s;
        rng = view_range << 15;
        w = panel_width;
        h = panel_height;
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        if (ax > rng || ay > rng) begin
            if (ry > rx) begin
                if (ry > -rx) begin
                    ox = (rx * w) / ry; oy = h;
                end else begin
                    oy = -((ry * h) / rx); ox = -w;
                end
            end else begin
                if (ry > -rx) begin
                    oy = (ry * h) / rx; ox = w;
                end else begin
                    ox = -((rx * w) / ry); oy = -h;
                end
            end
        end else if (rng == 0) begin
            ox = 0; oy = 0;
        end else begin
            ox = (rx * w) / rng;
            oy = (ry * h) / rng;
        end
        px.sx = SB'(clamp_pixel(panel_left, w, ox));
        px.sy = SB'(clamp_pixel(panel_top, h, oy));
        return px;
    endfunction

    task automatic write_reg(t_cfg_reg idx, longint value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_DATA_BITS'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_VIEW_RANGE:   view_range = value & 16'hFFFF;
            REG_PANEL_LEFT:   panel_left = value & 11'h7FF;
            REG_PANEL_TOP:    panel_top = value & 11'h7FF;
            REG_PANEL_WIDTH:  panel_width = value & 12'hFFF;
            default:          panel_height = value & 12'hFFF;
        endcase
    endtask

    task automatic load_panel(longint rng, longint l, longint t, longint w, longint h);
        write_reg(REG_VIEW_RANGE, rng);
        write_reg(REG_PANEL_LEFT, l);
        write_reg(REG_PANEL_TOP, t);
        write_reg(REG_PANEL_WIDTH, w);
        write_reg(REG_PANEL_HEIGHT, h);
    endtask

    task automatic drain;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic send_point(t_point p);
        while (src_idle_ok && $urandom_range(99) < 34) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.target_x <= p.tx;
        in_ch.target_y <= p.ty;
        in_ch.viewer_x <= p.vx;
        in_ch.viewer_y <= p.vy;
        in_ch.view_yaw <= p.yaw;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        pixels_due.push_back(radar_pixel(p));
    endtask

    task automatic end_burst;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
    endtask

    function automatic t_point rand_point(int mode);
        t_point p;
        int span;
        p.yaw = AB'($urandom);
        if (mode == 0) begin
            p.tx = CB'($urandom); p.ty = CB'($urandom);
            p.vx = CB'($urandom); p.vy = CB'($urandom);
        end else begin
            span = (mode == 1) ? int'(view_range) + 8 : 3 * int'(view_range) + 8;
            if (span > 60000) span = 60000;
            p.vx = CB'($urandom_range(32767) - 16384);
            p.vy = CB'($urandom_range(32767) - 16384);
            p.tx = p.vx + CB'(int'($urandom_range(2 * span)) - span);
            p.ty = p.vy + CB'(int'($urandom_range(2 * span)) - span);
        end
        return p;
    endfunction

    always @(negedge i_clk) begin
        if (hold_off) out_ch.ready <= 1'b0;
        else out_ch.ready <= !(sink_idle_ok && $urandom_range(99) < 34);
    end

    always @(posedge i_clk) begin
        t_pixel exp_px;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat x=%0d y=%0d",
                    out_ch.screen_x, out_ch.screen_y);
            end else begin
                exp_px = pixels_due.pop_front();
                if (exp_px.sx !== out_ch.screen_x || exp_px.sy !== out_ch.screen_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                            exp_px.sx, exp_px.sy, out_ch.screen_x, out_ch.screen_y);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    t_row directed[$];

    function automatic t_point mk(int tx, int ty, int vx, int vy, int yaw);
        t_point p;
        p.tx = CB'(tx); p.ty = CB'(ty); p.vx = CB'(vx); p.vy = CB'(vy); p.yaw = AB'(yaw);
        return p;
    endfunction

    task automatic add_row(t_point p, logic known, int sx, int sy);
        t_row r;
        r.p = p; r.known = known; r.px.sx = SB'(sx); r.px.sy = SB'(sy);
        directed.push_back(r);
    endtask

    initial begin
        t_row r;
        int phase_i;
        view_range = 2048; panel_left = 0; panel_top = 0;
        panel_width = 200; panel_height = 200;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // point at the viewer lands on the panel center
        add_row(mk(0, 0, 0, 0, 0), 1, 100, 100);
        add_row(mk(-65536, -65536, -65536, -65536, 65535), 1, 100, 100);
        // far corners clamp to the panel edges; later rows mix in-range and out-of-range points
        add_row(mk(65535, 65535, -65536, -65536, 0), 0, 0, 0);
        add_row(mk(-65536, -65536, 65535, 65535, 0), 0, 0, 0);
        add_row(mk(65535, -65536, -65536, 65535, 16384), 0, 0, 0);
        add_row(mk(-65536, 65535, 65535, -65536, 32768), 0, 0, 0);
        add_row(mk(0, 5000, 0, 0, 49152), 0, 0, 0);
        add_row(mk(5000, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(0, -5000, 0, 0, 0), 0, 0, 0);
        add_row(mk(-5000, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(3000, 3000, 0, 0, 8192), 0, 0, 0);
        add_row(mk(2048, 0, 0, 0, 16384), 0, 0, 0);
        add_row(mk(2049, 0, 0, 0, 0), 0, 0, 0);
        add_row(mk(1000, -700, 20, 30, 12345), 0, 0, 0);
        add_row(mk(-1500, 1800, 0, 0, 65535), 0, 0, 0);
        add_row(mk(-3000, -3000, 0, 0, 40000), 0, 0, 0);
        add_row(mk(65535, 0, -65536, 0, 1), 0, 0, 0);
        add_row(mk(0, 65535, 0, -65536, 24576), 0, 0, 0);
        for (int i = 0; i < directed.size(); i++) begin
            r = directed[i];
            send_point(r.p);
            if (r.known) pixels_due[$] = r.px;
        end
        end_burst();
        drain();

        // zero range, small panel
        load_panel(0, 2047, 2047, 6, 6);
        send_point(mk(0, 0, 5, 5, 0));
        send_point(mk(1, 0, 0, 0, 0));
        send_point(mk(-65536, 65535, 65535, -65536, 777));
        send_point(mk(0, -1, 0, 0, 30000));
        end_burst();
        drain();

        // narrow panel and wide-result saturation
        load_panel(65535, 2047, 1000, 2048, 2048);
        send_point(mk(65535, 65535, -65536, -65536, 0));
        send_point(mk(-65536, -65536, 65535, 65535, 9000));
        send_point(mk(10, -10, 0, 0, 60000));
        end_burst();
        drain();
        load_panel(1, 0, 0, 4, 3);
        send_point(mk(100, 100, 0, 0, 0));
        send_point(mk(0, 0, 0, 0, 0));
        end_burst();
        drain();

        for (phase_i = 0; phase_i < 5; phase_i++) begin
            case (phase_i)
                0: load_panel(2048, 0, 0, 200, 200);
                1: load_panel(65535, 1024, 1536, 2048, 600);
                2: load_panel(1, 2047, 0, 6, 2048);
                3: load_panel($urandom_range(65535, 1), $urandom_range(2047),
                              $urandom_range(2047), $urandom_range(2048, 6),
                              $urandom_range(2048, 6));
                default: load_panel(300, 500, 500, 1000, 1000);
            endcase
            src_idle_ok = (phase_i != 2);
            sink_idle_ok = (phase_i != 2);
            if (phase_i == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (200) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int k = 0; k < N_RANDOM / 5; k++)
                send_point(rand_point($urandom_range(2)));
            end_burst();
            drain();
        end
        src_idle_ok = 1'b1;
        sink_idle_ok = 1'b1;

        if (mismatches == 0 && pixels_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
